@@ rtl/sample_player_interp_loop_unit_assert.svh @@
// Assertion macros shared by the sample player RTL.
`ifndef SAMPLE_PLAYER_INTERP_LOOP_UNIT_ASSERT_SVH
`define SAMPLE_PLAYER_INTERP_LOOP_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SPL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sample player assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SPL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sample player assertion failed");

`endif

@@ rtl/spl_pkg.sv @@
`default_nettype none

package spl_pkg;

    localparam int FRAME_DEPTH_DEF  = 65536;
    localparam int MAX_CHANNELS_DEF = 2;
    localparam int LEN_CAP_MAX      = 65536;
    localparam int STEP_ONE         = 65536;
    localparam int NEAR_ONE_TOL     = 65;

    localparam int SAMPLE_W   = 16;
    localparam int IDX_W      = 16;
    localparam int LEN_W      = 17;
    localparam int STEP_W     = 20;
    localparam int GAIN_W     = 17;
    localparam int POS_W      = 33;
    localparam int FRAC_W     = 16;
    localparam int REM_NUM_W  = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_SEEK  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUFFER_LENGTH = 2'd0,
        CFG_STEP          = 2'd1,
        CFG_LOOPING       = 2'd2,
        CFG_CHANNEL_COUNT = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_REM_UP,
        ST_REM_POS,
        ST_READ_B,
        ST_MIX,
        ST_MUL,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

@@ rtl/spl_in_if.sv @@
`default_nettype none

interface spl_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            cmd;
    logic [spl_pkg::IDX_W-1:0]             frame_index;
    logic signed [spl_pkg::SAMPLE_W-1:0]   sample_a;
    logic signed [spl_pkg::SAMPLE_W-1:0]   sample_b;
    logic [spl_pkg::GAIN_W-1:0]            gain;
    logic [spl_pkg::POS_W-1:0]             seek_position;

    modport source (
        output valid, cmd, frame_index, sample_a, sample_b, gain, seek_position,
        input  ready
    );
    modport sink (
        input  valid, cmd, frame_index, sample_a, sample_b, gain, seek_position,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/spl_out_if.sv @@
`default_nettype none

interface spl_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [spl_pkg::SAMPLE_W-1:0]   out_a;
    logic signed [spl_pkg::SAMPLE_W-1:0]   out_b;
    logic                                  looped;
    logic                                  finished;

    modport source (
        output valid, out_a, out_b, looped, finished,
        input  ready
    );
    modport sink (
        input  valid, out_a, out_b, looped, finished,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/spl_store.sv @@
`default_nettype none

module spl_store #(
    parameter int FRAME_DEPTH = spl_pkg::FRAME_DEPTH_DEF,
    parameter int DATA_W      = 2 * spl_pkg::SAMPLE_W
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_wr_en,
    input  wire logic [$clog2(FRAME_DEPTH)-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0]              i_wr_data,
    input  wire logic                           i_rd_en,
    input  wire logic [$clog2(FRAME_DEPTH)-1:0] i_rd_addr,
    output logic      [DATA_W-1:0]              o_rd_data
);

    logic [DATA_W-1:0] r_mem [FRAME_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read, so a fetched frame can wait.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/spl_rem.sv @@
`default_nettype none

module spl_rem (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [spl_pkg::REM_NUM_W-1:0]   i_num,
    input  wire logic [spl_pkg::LEN_W-1:0]       i_den,
    output logic                                 o_done,
    output logic      [spl_pkg::LEN_W-1:0]       o_rem
);

    localparam int NW = spl_pkg::REM_NUM_W;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_part;
    logic [NW-1:0] w_shift;
    logic [NW-1:0] w_den;
    logic [NW-1:0] w_next;

    // Restoring remainder, one dividend bit per cycle.
    assign w_den   = NW'(i_den);
    assign w_shift = {r_part[NW-2:0], r_num[NW-1]};
    assign w_next  = (w_shift >= w_den) ? (w_shift - w_den) : w_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_part <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[NW-2:0], 1'b0};
            r_part <= w_next;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_part[spl_pkg::LEN_W-1:0];

endmodule

`default_nettype wire

@@ rtl/spl_mix.sv @@
`default_nettype none

module spl_mix (
    input  wire logic                                i_clk,
    input  wire logic                                i_load,
    input  wire logic signed [spl_pkg::SAMPLE_W-1:0] i_f1,
    input  wire logic signed [spl_pkg::SAMPLE_W-1:0] i_f2,
    input  wire logic        [spl_pkg::FRAC_W-1:0]   i_frac,
    input  wire logic        [spl_pkg::GAIN_W-1:0]   i_gain,
    output logic signed      [spl_pkg::SAMPLE_W-1:0] o_y
);

    logic signed [16:0] w_diff;
    logic signed [33:0] w_term;
    logic signed [33:0] w_acc;
    logic signed [31:0] r_acc;
    logic [spl_pkg::GAIN_W-1:0] r_gain;
    logic signed [49:0] r_prod;
    logic signed [49:0] w_round;
    logic signed [17:0] w_y;

    // f1*(1-frac) + f2*frac is rewritten as f1 + (f2-f1)*frac; it fits 32 bits.
    assign w_diff = 17'(i_f2) - 17'(i_f1);
    assign w_term = w_diff * $signed({1'b0, i_frac});
    assign w_acc  = $signed({{2{i_f1[15]}}, i_f1, 16'd0}) + w_term;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_acc  <= w_acc[31:0];
            r_gain <= i_gain;
        end
        r_prod <= r_acc * $signed({1'b0, r_gain});
    end

    // Adding one half and flooring rounds to nearest with ties upward.
    assign w_round = r_prod + 50'sh0_8000_0000;
    assign w_y     = w_round[49:32];

    always_comb begin
        if (w_y > 18'sd32767) begin
            o_y = 16'sh7FFF;
        end else if (w_y < -18'sd32768) begin
            o_y = 16'sh8000;
        end else begin
            o_y = w_y[15:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/sample_player_interp_loop_unit.sv @@
// Sample player with linear interpolation, looping and one-shot end handling.
// Requests arrive on i_item (valid/ready): a frame write, a seek, a tick or none.
// Every request produces exactly one result on o_result; only a tick carries
// audio, the others return zeros. Registers are set on the i_cfg_* write port;
// the user must write them only while no request is in flight, which the block
// itself does not enforce. Flow: writes, seeks and silent ticks go from
// acceptance through ST_DECIDE and ST_FIN to the result register; an audible
// tick also passes ST_READ_B, ST_MIX and ST_MUL, set by the single store read
// port (two frames fetched one after the other) and the two-stage multiplier.
// A looping tick whose next frame or new position lies more than one loop length
// away adds a one-bit-per-cycle remainder pass for each of those two cases.
// One request is worked at a time; i_item.ready is high while the block idles.
// The result register holds a result until o_result.ready takes it; the next
// request is accepted meanwhile, and its result waits until the register frees.
// Reset clears position, finished mark and registers to their defaults; the
// frame store is not cleared and must be written before it is played.
`default_nettype none

`include "sample_player_interp_loop_unit_assert.svh"

module sample_player_interp_loop_unit #(
    parameter int FRAME_DEPTH  = spl_pkg::FRAME_DEPTH_DEF,
    parameter int MAX_CHANNELS = spl_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    spl_in_if.sink                                i_item,
    spl_out_if.source                             o_result,
    input  wire logic                             i_cfg_we,
    input  wire logic [spl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [spl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW      = $clog2(FRAME_DEPTH);
    localparam int DW      = spl_pkg::SAMPLE_W * MAX_CHANNELS;
    localparam int LEN_CAP = (FRAME_DEPTH < spl_pkg::LEN_CAP_MAX) ? FRAME_DEPTH
                                                                   : spl_pkg::LEN_CAP_MAX;
    localparam int LW      = spl_pkg::LEN_W;
    localparam int PW      = spl_pkg::POS_W;

    spl_pkg::t_state r_state;
    spl_pkg::t_state n_state;

    // Latched request.
    spl_pkg::t_cmd               r_cmd;
    logic [spl_pkg::IDX_W-1:0]   r_frame_index;
    logic signed [15:0]          r_sample_a;
    logic signed [15:0]          r_sample_b;
    logic [spl_pkg::GAIN_W-1:0]  r_gain;
    logic [PW-1:0]               r_seek;

    // Configuration.
    logic [LW-1:0]                r_len_cfg;
    logic [spl_pkg::STEP_W-1:0]   r_step;
    logic                         r_looping;
    logic [1:0]                   r_chan_cnt;

    // Player state.
    logic [PW-1:0] r_pos;
    logic          r_fin_sent;

    // Per-request work registers.
    logic [PW+0:0]  r_sum;
    logic [PW-1:0]  r_np;
    logic [LW-1:0]  r_upper;
    logic [15:0]    r_frac;
    logic [DW-1:0]  r_fa;
    logic           r_upd_pos;
    logic           r_fin_set;
    logic           r_clr_fin;
    logic           r_silent;
    logic           r_wrap;
    logic           r_lp_chk;
    logic           r_near;
    logic           r_need_np;
    logic           r_va;
    logic           r_vb;

    // Result register.
    logic               r_out_valid;
    logic signed [15:0] r_out_a;
    logic signed [15:0] r_out_b;
    logic               r_out_looped;
    logic               r_out_finished;

    logic            w_accept;
    logic            w_out_free;
    logic            w_fin_load;
    logic [LW-1:0]   w_len;
    logic [PW-1:0]   w_end;
    logic [LW-1:0]   w_lower;
    logic [PW:0]     w_sum;
    logic [PW:0]     w_sum_d;
    logic            w_sum_lt;
    logic            w_sum_d_lt;
    logic [spl_pkg::STEP_W-1:0] w_dist;
    logic            w_near;
    logic [PW:0]     w_round_pos;
    logic [LW:0]     w_p;
    logic            w_near_end;
    logic [LW-1:0]   w_pa;
    logic            w_pb_end;
    logic            w_tick;
    logic            w_play;
    logic            w_need_up;
    logic            w_need_np;
    logic            w_two;
    logic [LW-1:0]   w_addr_a;
    logic [LW-1:0]   w_lower_inc;

    logic                          w_rem_start;
    logic [spl_pkg::REM_NUM_W-1:0] w_rem_num;
    logic                          w_rem_done;
    logic [LW-1:0]                 w_rem;
    logic [LW-1:0]                 w_rem_inc;

    logic            w_wr_en;
    logic [DW-1:0]   w_wr_data;
    logic            w_rd_en;
    logic [AW-1:0]   w_rd_addr;
    logic [DW-1:0]   w_rd_data;
    logic            w_mix_load;

    logic signed [15:0] w_y [MAX_CHANNELS];
    logic signed [15:0] w_y_b;

    assign w_accept   = i_item.valid && i_item.ready;
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_fin_load = (r_state == spl_pkg::ST_FIN) && w_out_free;
    assign i_item.ready = (r_state == spl_pkg::ST_IDLE);

    // ---------------------------------------------------------------- decisions
    assign w_len = (r_len_cfg > LW'(LEN_CAP)) ? LW'(LEN_CAP) : r_len_cfg;
    assign w_end = {w_len, 16'd0};
    assign w_lower     = r_pos[PW-1:16];
    assign w_lower_inc = w_lower + LW'(1);
    assign w_sum       = (PW+1)'(r_pos) + (PW+1)'(r_step);
    assign w_sum_lt    = w_sum < (PW+1)'(w_end);
    assign w_sum_d     = w_sum - (PW+1)'(w_end);
    assign w_sum_d_lt  = w_sum_d < (PW+1)'(w_end);

    assign w_dist = (r_step > spl_pkg::STEP_W'(spl_pkg::STEP_ONE))
                  ? (r_step - spl_pkg::STEP_W'(spl_pkg::STEP_ONE))
                  : (spl_pkg::STEP_W'(spl_pkg::STEP_ONE) - r_step);
    assign w_near = w_dist <= spl_pkg::STEP_W'(spl_pkg::NEAR_ONE_TOL);

    // Near unit step: play the nearest frame, restarting at zero past the end.
    assign w_round_pos = (PW+1)'(r_pos) + (PW+1)'(17'h08000);
    assign w_p         = w_round_pos[PW:16];
    assign w_near_end  = w_p >= (LW+1)'(w_len);
    assign w_pa        = w_near_end ? '0 : w_p[LW-1:0];

    assign w_pb_end  = !r_looping && (r_pos >= w_end);
    assign w_tick    = (r_cmd == spl_pkg::CMD_TICK) && (w_len != '0);
    assign w_play    = w_tick && (w_near ? (!w_near_end || r_looping) : !w_pb_end);
    assign w_need_up = w_play && !w_near && r_looping && !(w_lower < w_len);
    assign w_need_np = w_play && !w_near && r_looping && !w_sum_lt && !w_sum_d_lt;
    assign w_two     = (MAX_CHANNELS >= 2) && r_chan_cnt[1];
    assign w_addr_a  = w_near ? w_pa : w_lower;

    // ---------------------------------------------------------------- remainder
    assign w_rem_start = ((r_state == spl_pkg::ST_DECIDE) && (w_need_up || w_need_np))
                      || ((r_state == spl_pkg::ST_REM_UP) && w_rem_done && r_need_np);
    assign w_rem_num = (r_state == spl_pkg::ST_DECIDE)
                     ? (w_need_up ? spl_pkg::REM_NUM_W'(w_lower) : w_sum[PW:16])
                     : r_sum[PW:16];
    assign w_rem_inc = w_rem + LW'(1);

    spl_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rem_start),
        .i_num   (w_rem_num),
        .i_den   (w_len),
        .o_done  (w_rem_done),
        .o_rem   (w_rem)
    );

    // ---------------------------------------------------------------- store
    assign w_wr_en   = (r_state == spl_pkg::ST_DECIDE) && (r_cmd == spl_pkg::CMD_WRITE)
                    && (32'(r_frame_index) < FRAME_DEPTH);
    assign w_wr_data = DW'({r_sample_b, r_sample_a});
    assign w_rd_en   = ((r_state == spl_pkg::ST_DECIDE) && (r_cmd == spl_pkg::CMD_TICK))
                    || (r_state == spl_pkg::ST_READ_B);
    assign w_rd_addr = (r_state == spl_pkg::ST_DECIDE) ? AW'(w_addr_a) : AW'(r_upper);

    spl_store #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .DATA_W      (DW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(r_frame_index)),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // ---------------------------------------------------------------- mix lanes
    assign w_mix_load = (r_state == spl_pkg::ST_MIX);

    for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
        logic signed [15:0] w_f1;
        logic signed [15:0] w_f2;

        // Frames past the end of the buffer read as silence.
        assign w_f1 = r_va ? r_fa[16*g +: 16] : '0;
        assign w_f2 = r_vb ? w_rd_data[16*g +: 16] : '0;

        spl_mix u_mix (
            .i_clk  (i_clk),
            .i_load (w_mix_load),
            .i_f1   (w_f1),
            .i_f2   (w_f2),
            .i_frac (r_frac),
            .i_gain (r_gain),
            .o_y    (w_y[g])
        );
    end

    if (MAX_CHANNELS >= 2) begin : g_chan_b
        assign w_y_b = w_y[MAX_CHANNELS-1];
    end else begin : g_no_chan_b
        assign w_y_b = '0;
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            spl_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = spl_pkg::ST_DECIDE;
                end
            end
            spl_pkg::ST_DECIDE: begin
                if (!w_play) begin
                    n_state = spl_pkg::ST_FIN;
                end else if (w_need_up) begin
                    n_state = spl_pkg::ST_REM_UP;
                end else if (w_need_np) begin
                    n_state = spl_pkg::ST_REM_POS;
                end else begin
                    n_state = spl_pkg::ST_READ_B;
                end
            end
            spl_pkg::ST_REM_UP: begin
                if (w_rem_done) begin
                    n_state = r_need_np ? spl_pkg::ST_REM_POS : spl_pkg::ST_READ_B;
                end
            end
            spl_pkg::ST_REM_POS: begin
                if (w_rem_done) begin
                    n_state = spl_pkg::ST_READ_B;
                end
            end
            spl_pkg::ST_READ_B: n_state = spl_pkg::ST_MIX;
            spl_pkg::ST_MIX:    n_state = spl_pkg::ST_MUL;
            spl_pkg::ST_MUL:    n_state = spl_pkg::ST_FIN;
            spl_pkg::ST_FIN: begin
                if (w_out_free) begin
                    n_state = spl_pkg::ST_IDLE;
                end
            end
            default: n_state = spl_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg  <= '0;
            r_step     <= spl_pkg::STEP_W'(spl_pkg::STEP_ONE);
            r_looping  <= 1'b0;
            r_chan_cnt <= 2'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                spl_pkg::CFG_BUFFER_LENGTH: r_len_cfg  <= i_cfg_data[LW-1:0];
                spl_pkg::CFG_STEP:          r_step     <= i_cfg_data;
                spl_pkg::CFG_LOOPING:       r_looping  <= i_cfg_data[0];
                spl_pkg::CFG_CHANNEL_COUNT: r_chan_cnt <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- player state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_fin_sent <= 1'b0;
        end else if (w_fin_load) begin
            if (r_upd_pos) begin
                r_pos <= r_np;
            end
            if (r_fin_set) begin
                r_fin_sent <= 1'b1;
            end else if (r_clr_fin) begin
                r_fin_sent <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- request data
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd         <= spl_pkg::t_cmd'(i_item.cmd);
            r_frame_index <= i_item.frame_index;
            r_sample_a    <= i_item.sample_a;
            r_sample_b    <= i_item.sample_b;
            r_gain        <= i_item.gain;
            r_seek        <= i_item.seek_position;
        end

        case (r_state)
            spl_pkg::ST_DECIDE: begin
                r_upd_pos <= 1'b0;
                r_fin_set <= 1'b0;
                r_clr_fin <= 1'b0;
                r_silent  <= 1'b1;
                r_wrap    <= 1'b0;
                r_lp_chk  <= 1'b0;
                r_near    <= w_near;
                r_need_np <= w_need_np;
                r_sum     <= w_sum;
                r_frac    <= '0;
                r_va      <= 1'b0;
                r_np      <= w_end;
                r_upper   <= w_lower_inc;
                case (r_cmd)
                    spl_pkg::CMD_SEEK: begin
                        r_np      <= (r_seek < w_end) ? r_seek : w_end;
                        r_upd_pos <= 1'b1;
                        r_clr_fin <= 1'b1;
                    end
                    spl_pkg::CMD_TICK: begin
                        if (w_tick) begin
                            r_upd_pos <= 1'b1;
                            if (!w_play) begin
                                // One-shot end: silent, clamp, mark finished.
                                r_fin_set <= 1'b1;
                            end else if (w_near) begin
                                r_silent <= 1'b0;
                                r_wrap   <= w_near_end;
                                r_va     <= 1'b1;
                                r_np     <= {w_pa + LW'(1), 16'd0};
                            end else begin
                                r_silent <= 1'b0;
                                r_frac   <= r_pos[15:0];
                                r_va     <= w_lower < w_len;
                                if (r_looping) begin
                                    r_lp_chk <= 1'b1;
                                    r_upper  <= (w_lower_inc == w_len) ? '0 : w_lower_inc;
                                    r_np     <= w_sum_lt ? w_sum[PW-1:0] : w_sum_d[PW-1:0];
                                end else begin
                                    r_np <= w_sum_lt ? w_sum[PW-1:0] : w_end;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            spl_pkg::ST_REM_UP: begin
                if (w_rem_done) begin
                    r_upper <= (w_rem_inc == w_len) ? '0 : w_rem_inc;
                end
            end
            spl_pkg::ST_REM_POS: begin
                if (w_rem_done) begin
                    r_np <= {w_rem, r_sum[15:0]};
                end
            end
            spl_pkg::ST_READ_B: begin
                r_fa <= w_rd_data;
                r_vb <= !r_near && (r_upper < w_len);
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_load) begin
            r_out_a        <= r_silent ? '0 : w_y[0];
            r_out_b        <= (r_silent || !w_two) ? '0 : w_y_b;
            r_out_looped   <= r_wrap || (r_lp_chk && (r_np < r_pos));
            r_out_finished <= r_fin_set && !r_fin_sent;
        end
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.out_a    = r_out_a;
    assign o_result.out_b    = r_out_b;
    assign o_result.looped   = r_out_looped;
    assign o_result.finished = r_out_finished;

    // ---------------------------------------------------------------- checks
    `SPL_ASSERT_NXT(a_accept_decides, i_clk, i_rst_n, w_accept, r_state == spl_pkg::ST_DECIDE)
    `SPL_ASSERT_IMP(a_rem_done_awaited, i_clk, i_rst_n, w_rem_done, r_state == spl_pkg::ST_REM_UP || r_state == spl_pkg::ST_REM_POS)
    `SPL_ASSERT_IMP(a_pos_in_range, i_clk, i_rst_n, 1'b1, r_pos <= 33'h1_0000_0000)
    `SPL_ASSERT_NXT(a_finish_marked, i_clk, i_rst_n, w_fin_load && r_fin_set, r_fin_sent)

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import spl_pkg::*;

    typedef struct packed {
        t_cmd               cmd;
        bit [15:0]          frame_index;
        bit signed [15:0]   sample_a;
        bit signed [15:0]   sample_b;
        bit [16:0]          gain;
        bit [32:0]          seek_position;
    } request_t;

    typedef struct packed {
        bit signed [15:0]   out_a;
        bit signed [15:0]   out_b;
        bit                 looped;
        bit                 finished;
    } result_t;

    class player_scoreboard;
        bit [31:0]   frames [0:65535];
        bit          written [0:65535];
        bit [32:0]   position;
        bit          done_sent;
        bit [16:0]   buf_len;
        bit [19:0]   step;
        bit          loop_on;
        bit [1:0]    chans;
        result_t     pending_outputs[$];
        int          errors;

        function new();
            position = 0;
            done_sent = 0;
            buf_len = 0;
            step = STEP_ONE;
            loop_on = 0;
            chans = 1;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, bit [19:0] data);
            case (idx)
                CFG_BUFFER_LENGTH: buf_len = data[16:0];
                CFG_STEP:          step = data;
                CFG_LOOPING:       loop_on = data[0];
                CFG_CHANNEL_COUNT: chans = data[1:0];
                default: ;
            endcase
        endfunction

        function longint span();
            return (buf_len > LEN_CAP_MAX) ? longint'(LEN_CAP_MAX) : longint'(buf_len);
        endfunction

        function bit near_unit();
            longint d;
            d = (step > STEP_ONE) ? longint'(step) - STEP_ONE : STEP_ONE - longint'(step);
            return d <= NEAR_ONE_TOL;
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction

        // Frame indexes that the next tick will fetch from the store, -1 for none.
        function void tick_reads(output longint ra, output longint rb);
            longint len, endp, pos, lower, upper, p;
            ra = -1;
            rb = -1;
            len = span();
            endp = len << 16;
            pos = position;
            if (len == 0) return;
            if (!near_unit()) begin
                if (!loop_on && pos >= endp) return;
                lower = pos >> 16;
                upper = lower + 1;
                if (loop_on) upper = upper % len;
                if (lower < len) ra = lower;
                if (upper < len) rb = upper;
            end else begin
                p = (pos + 'h8000) >> 16;
                if (p >= len) begin
                    if (!loop_on) return;
                    p = 0;
                end
                ra = p;
            end
        endfunction

        function void fetch(longint idx, longint len, output int c0, output int c1);
            bit [31:0] w;
            c0 = 0;
            c1 = 0;
            if (idx < len) begin
                w = frames[idx];
                c0 = int'($signed(w[15:0]));
                c1 = int'($signed(w[31:16]));
            end
        endfunction

        // Linear blend of two samples, scaled by gain and rounded to nearest.
        function bit signed [15:0] blend(int f1, int f2, longint frac, longint g);
            longint acc, v, y;
            acc = longint'(f1) * (65536 - frac) + longint'(f2) * frac;
            v = acc * g + (longint'(1) << 31);
            y = v >>> 32;
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            return y[15:0];
        endfunction

        function void play_tick(longint g, ref result_t e);
            longint len, endp, pos, lower, upper, frac, np, p;
            int a1, b1, a2, b2;
            bit two, audible;
            len = span();
            endp = len << 16;
            pos = position;
            two = chans >= 2;
            if (len == 0) return;
            if (!near_unit()) begin
                lower = pos >> 16;
                frac = pos & 'hFFFF;
                if (!loop_on && pos >= endp) begin
                    if (!done_sent) begin
                        e.finished = 1;
                        done_sent = 1;
                    end
                    position = endp;
                end else begin
                    upper = lower + 1;
                    if (loop_on) upper = upper % len;
                    fetch(lower, len, a1, b1);
                    fetch(upper, len, a2, b2);
                    e.out_a = blend(a1, a2, frac, g);
                    if (two) e.out_b = blend(b1, b2, frac, g);
                    if (loop_on) begin
                        np = (pos + step) % endp;
                        if (np < pos) e.looped = 1;
                    end else begin
                        np = pos + step;
                        if (np > endp) np = endp;
                    end
                    position = np;
                end
            end else begin
                // Close enough to unit speed: play the nearest frame as is.
                p = (pos + 'h8000) >> 16;
                audible = 1;
                if (p >= len) begin
                    if (loop_on) begin
                        p = 0;
                        e.looped = 1;
                    end else begin
                        if (!done_sent) begin
                            e.finished = 1;
                            done_sent = 1;
                        end
                        position = endp;
                        audible = 0;
                    end
                end
                if (audible) begin
                    fetch(p, len, a1, b1);
                    e.out_a = blend(a1, 0, 0, g);
                    if (two) e.out_b = blend(b1, 0, 0, g);
                    position = (p + 1) << 16;
                end
            end
        endfunction

        function void note_request(request_t r);
            result_t e;
            longint endp;
            e = '0;
            endp = span() << 16;
            case (r.cmd)
                CMD_WRITE: begin
                    frames[r.frame_index] = {r.sample_b, r.sample_a};
                    written[r.frame_index] = 1;
                end
                CMD_SEEK: begin
                    position = (longint'(r.seek_position) < endp) ? r.seek_position : endp;
                    done_sent = 0;
                end
                CMD_TICK: play_tick(r.gain, e);
                default: ;
            endcase
            pending_outputs.push_back(e);
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (pending_outputs.size() == 0) begin
                $error("result with no request outstanding: out_a %0d out_b %0d",
                       got.out_a, got.out_b);
                errors++;
                return;
            end
            e = pending_outputs.pop_front();
            if (got.out_a !== e.out_a) begin
                $error("out_a: expected %0d, got %0d", e.out_a, got.out_a);
                errors++;
            end
            if (got.out_b !== e.out_b) begin
                $error("out_b: expected %0d, got %0d", e.out_b, got.out_b);
                errors++;
            end
            if (got.looped !== e.looped) begin
                $error("looped: expected %0d, got %0d", e.looped, got.looped);
                errors++;
            end
            if (got.finished !== e.finished) begin
                $error("finished: expected %0d, got %0d", e.finished, got.finished);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int src_idle_pct;
    int snk_stall_pct;
    player_scoreboard sb;

    spl_in_if  item_if ();
    spl_out_if res_if ();

    sample_player_interp_loop_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_item      (item_if),
        .o_result    (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial begin
        #10_000_000;
        $display("tb: errors");
        $finish;
    end

    // Result side: random back-pressure set at each falling edge.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge clk) begin
        result_t got;
        if (rst_n && res_if.valid && res_if.ready) begin
            got.out_a = res_if.out_a;
            got.out_b = res_if.out_b;
            got.looped = res_if.looped;
            got.finished = res_if.finished;
            sb.check_result(got);
        end
    end

    task automatic set_mode(int m);
        case (m % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 86; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 86; end
            default: begin src_idle_pct = 17; snk_stall_pct = 17; end
        endcase
    endtask

    task automatic configure(bit [19:0] len, bit [19:0] stp, bit [19:0] lp, bit [19:0] ch);
        t_cfg_reg regs [4];
        bit [19:0] vals [4];
        regs = '{CFG_BUFFER_LENGTH, CFG_STEP, CFG_LOOPING, CFG_CHANNEL_COUNT};
        vals = '{len, stp, lp, ch};
        for (int i = 0; i < 4; i++) begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            sb.set_reg(regs[i], vals[i]);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_request(request_t r);
        @(negedge clk);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.cmd <= r.cmd;
        item_if.frame_index <= r.frame_index;
        item_if.sample_a <= r.sample_a;
        item_if.sample_b <= r.sample_b;
        item_if.gain <= r.gain;
        item_if.seek_position <= r.seek_position;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
        sb.note_request(r);
    endtask

    // Lets every outstanding request come back before registers change.
    task automatic drain();
        @(negedge clk);
        item_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic request_t mk(t_cmd c, int idx, int a, int b, int g, longint s);
        request_t r;
        r.cmd = c;
        r.frame_index = idx;
        r.sample_a = a;
        r.sample_b = b;
        r.gain = g;
        r.seek_position = s;
        return r;
    endfunction

    function automatic bit [15:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic request_t random_request();
        request_t r;
        longint len, endp, ra, rb;
        int roll;
        len = sb.span();
        endp = len << 16;
        r.frame_index = $urandom;
        r.sample_a = pick_sample();
        r.sample_b = pick_sample();
        case ($urandom_range(9))
            0: r.gain = 0;
            1: r.gain = 65536;
            2: r.gain = 17'h1FFFF;
            3, 4: r.gain = $urandom;
            default: r.gain = $urandom_range(65536, 0);
        endcase
        r.seek_position = 33'({$urandom_range(1, 0), $urandom});
        roll = $urandom_range(99);
        if (roll < 62) begin
            r.cmd = CMD_TICK;
        end else if (roll < 77) begin
            r.cmd = CMD_SEEK;
            case ($urandom_range(3))
                0, 1: r.seek_position = longint'(r.seek_position) % (endp + 1);
                2: r.seek_position = ($urandom_range(1)) ? endp : 0;
                default: ;
            endcase
        end else if (roll < 94) begin
            r.cmd = CMD_WRITE;
            if (len != 0 && $urandom_range(3) != 0) r.frame_index = $urandom_range(len - 1, 0);
        end else begin
            r.cmd = CMD_NONE;
        end
        // A tick must never fetch a frame that was never stored; write it first.
        if (r.cmd == CMD_TICK) begin
            sb.tick_reads(ra, rb);
            if (ra >= 0 && !sb.written[ra]) begin
                r.cmd = CMD_WRITE;
                r.frame_index = ra;
            end else if (rb >= 0 && !sb.written[rb]) begin
                r.cmd = CMD_WRITE;
                r.frame_index = rb;
            end
        end
        return r;
    endfunction

    initial begin
        bit [19:0] len_v, step_v, loop_v, ch_v;
        sb = new();
        set_mode(0);
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_if.valid = 1'b0;
        item_if.cmd = CMD_NONE;
        item_if.frame_index = '0;
        item_if.sample_a = '0;
        item_if.sample_b = '0;
        item_if.gain = '0;
        item_if.seek_position = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // One-shot at unit speed through a four-frame buffer, then past its end.
        configure(4, STEP_ONE, 0, 2);
        send_request(mk(CMD_WRITE, 0, 32767, -32768, 0, 0));
        send_request(mk(CMD_WRITE, 1, -32768, 32767, 0, 0));
        send_request(mk(CMD_WRITE, 2, -1, 1, 0, 0));
        send_request(mk(CMD_WRITE, 3, 1000, -1000, 0, 0));
        send_request(mk(CMD_WRITE, 65535, 21845, -21846, 0, 0));
        send_request(mk(CMD_TICK, 0, 0, 0, 65536, 0));
        send_request(mk(CMD_TICK, 0, 0, 0, 131071, 0));
        send_request(mk(CMD_TICK, 0, 0, 0, 0, 0));
        send_request(mk(CMD_TICK, 0, 0, 0, 65536, 0));
        send_request(mk(CMD_TICK, 0, 0, 0, 65536, 0));
        send_request(mk(CMD_TICK, 0, 0, 0, 65536, 0));
        send_request(mk(CMD_NONE, 0, 0, 0, 65536, 0));
        send_request(mk(CMD_SEEK, 0, 0, 0, 0, 64'h1_0000_0000));
        send_request(mk(CMD_TICK, 0, 0, 0, 65536, 0));
        drain();

        // Half-speed looping across the loop point, mono.
        set_mode(1);
        configure(4, 20'h08000, 1, 1);
        send_request(mk(CMD_SEEK, 0, 0, 0, 0, 64'h3_8000));
        send_request(mk(CMD_TICK, 0, 0, 0, 65536, 0));
        send_request(mk(CMD_TICK, 0, 0, 0, 40000, 0));
        send_request(mk(CMD_TICK, 0, 0, 0, 131071, 0));
        drain();

        // Empty buffer, then the full-size buffer wrapping at its last frame.
        set_mode(2);
        configure(0, STEP_ONE, 0, 2);
        send_request(mk(CMD_TICK, 0, 0, 0, 65536, 0));
        drain();
        set_mode(3);
        configure(65536, STEP_ONE + NEAR_ONE_TOL, 1, 3);
        send_request(mk(CMD_SEEK, 0, 0, 0, 0, 64'hFFFF_0000));
        send_request(mk(CMD_TICK, 0, 0, 0, 65536, 0));
        send_request(mk(CMD_TICK, 0, 0, 0, 65536, 0));
        drain();

        for (int k = 0; k < 12; k++) begin
            set_mode(k);
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5, 6: len_v = $urandom_range(64, 1);
                7: len_v = 65536;
                8: len_v = $urandom_range(131071, 0);
                default: len_v = 0;
            endcase
            case ($urandom_range(5))
                0: step_v = STEP_ONE - NEAR_ONE_TOL + $urandom_range(2 * NEAR_ONE_TOL, 0);
                1: step_v = ($urandom_range(1) ? STEP_ONE + NEAR_ONE_TOL + 1
                                               : STEP_ONE - NEAR_ONE_TOL - 1);
                2: step_v = $urandom_range(131072, 0);
                3: step_v = $urandom_range(32768, 1);
                4: step_v = $urandom;
                default: step_v = ($urandom_range(1)) ? 20'hFFFFF : 20'h0;
            endcase
            loop_v = $urandom_range(1);
            ch_v = $urandom_range(3);
            // The first phases pin the register extremes.
            case (k)
                0: begin len_v = 65536;  step_v = STEP_ONE; loop_v = 1; ch_v = 2; end
                1: begin len_v = 131071; step_v = 20'hFFFFF; loop_v = 0; ch_v = 3; end
                2: begin len_v = 1;      step_v = 0;        loop_v = 1; ch_v = 0; end
                3: begin len_v = 2; step_v = STEP_ONE - NEAR_ONE_TOL; loop_v = 0; ch_v = 1; end
                default: ;
            endcase
            configure(len_v, step_v, loop_v, ch_v);
            repeat (50) send_request(random_request());
            drain();
        end

        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
